// ===== rtl/scancode_line_editor_core_macros.svh =====
// Assertion macros shared by the line editor RTL.
// SCLE_ASSERT checks a property that is disabled while reset is high.
// SCLE_ASSERT_ALWAYS checks a property at every edge, reset included.
`ifndef SCANCODE_LINE_EDITOR_CORE_MACROS_SVH
`define SCANCODE_LINE_EDITOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SCLE_ASSERT(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("line editor assertion failed");
`define SCLE_ASSERT_ALWAYS(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) prop) \
    else $error("line editor assertion failed");
`else
`define SCLE_ASSERT(lbl, clk_sig, rst_sig, prop)
`define SCLE_ASSERT_ALWAYS(lbl, clk_sig, prop)
`endif

`endif

// ===== rtl/scle_pkg.sv =====
package scle_pkg;

  // Scancodes and status bits of interest.
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_CAPS         = 8'h3A;
  localparam logic [7:0] SC_BKSP         = 8'h0E;
  localparam logic [7:0] SC_ENTER        = 8'h1C;
  localparam logic [7:0] MAP_TOP         = 8'h39;
  localparam int unsigned RELEASE_BIT    = 7;
  localparam int unsigned READY_BIT      = 0;

  // Result kinds.
  localparam logic [1:0] KIND_ECHO    = 2'd0;
  localparam logic [1:0] KIND_ERASE   = 2'd1;
  localparam logic [1:0] KIND_NEWLINE = 2'd2;
  localparam logic [1:0] KIND_LINE    = 2'd3;

  // Command queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_BKSP,
    OP_ENTER
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  // Character maps for codes 0x00 through 0x39.
  localparam int unsigned MAP_SIZE = 58;

  localparam logic [7:0] MAP_LOWER [MAP_SIZE] = '{
    "?", "?", "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", "?", "?",
    "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", "?", "?",
    "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, 8'h60, "?", 8'h5C,
    "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", "?", "?", "?", " "
  };

  localparam logic [7:0] MAP_UPPER [MAP_SIZE] = '{
    "?", "?", "!", "@", 8'hA3, "$", "%", "^", "&", "*", "(", ")", "_", "+", "?", "?",
    "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", "?", "?",
    "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h27, 8'h60, "?", "|",
    "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", "?", "?", "?", " "
  };

endpackage

// ===== rtl/scancode_line_editor_core.sv =====
// Keyboard line editor for set-1 scancodes.
// Input channel (in_valid/in_ready): one beat carries status_byte and
// scan_code. Beats with status bit 0 clear, modifier keys, releases and codes
// above 0x39 produce nothing; the rest queue a command for the back end.
// Output channel (out_valid/out_ready): each beat carries result_kind,
// char_code and run_last; run_last marks the final beat caused by an input.
// A printable key gives one echo beat while the line has room, backspace on
// a non-empty line one erase beat, and Enter a newline beat followed by one
// beat per stored character, after which the line is empty.
// The first result of an input is offered on the output after the beat has
// passed the command queue and the output register. The back end issues one
// result beat per cycle while the receiver keeps taking them, and the line
// store's single read port paces the playback.
// A four-entry command queue sits between the front end and the back end,
// so input beats keep being taken while the receiver stalls, until the
// queue fills and in_ready drops. Results are held in the output register.
// Reset clears the shift and caps flags, the line and the queue; the
// contents of the line store are not cleared.
module scancode_line_editor_core #(
  parameter int unsigned LINE_DEPTH = 63
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] status_byte,
  input  logic [7:0] scan_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] result_kind,
  output logic [7:0] char_code,
  output logic       run_last
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  scle_pkg::cmd_t push_cmd;
  scle_pkg::cmd_t head;

  scle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .status_byte(status_byte),
    .scan_code  (scan_code),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  scle_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .head    (head)
  );

  scle_back #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_kind(result_kind),
    .char_code  (char_code),
    .run_last   (run_last)
  );

endmodule

// ===== rtl/scle_queue.sv =====
`include "scancode_line_editor_core_macros.svh"

module scle_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  scle_pkg::cmd_t     push_cmd,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output scle_pkg::cmd_t     head
);

  scle_pkg::cmd_t                  slots [scle_pkg::QUEUE_DEPTH];
  logic [scle_pkg::QPTR_W-1:0]     wr_ptr;
  logic [scle_pkg::QPTR_W-1:0]     rd_ptr;
  logic [scle_pkg::QCNT_W-1:0]     count;

  assign full  = (count == scle_pkg::QCNT_W'(scle_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Command storage; written only on a push.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end else begin
        count <= count;
      end
    end
  end

  `SCLE_ASSERT(a_no_push_when_full, clk, rst, !(push && full))
  `SCLE_ASSERT(a_no_pop_when_empty, clk, rst, !(pop && empty))

endmodule

// ===== rtl/scle_front.sv =====
module scle_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         status_byte,
  input  logic [7:0]         scan_code,
  input  logic               q_full,
  output logic               push,
  output scle_pkg::cmd_t     push_cmd
);

  logic shift_held;
  logic shift_held_next;
  logic caps_on;
  logic caps_on_next;
  logic accept;
  logic use_upper;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign use_upper = (shift_held != caps_on);

  // Classify one accepted beat: modifier keys change flags here, releases
  // and unmapped codes are dropped, the rest becomes a back-part command.
  always_comb begin
    shift_held_next = shift_held;
    caps_on_next    = caps_on;
    push            = 1'b0;
    push_cmd.op     = scle_pkg::OP_CHAR;
    push_cmd.ch     = '0;
    if (accept && status_byte[scle_pkg::READY_BIT]) begin
      priority if (scan_code == scle_pkg::SC_CAPS) begin
        caps_on_next = !caps_on;
      end else if (scan_code == scle_pkg::SC_LSHIFT_MAKE ||
                   scan_code == scle_pkg::SC_RSHIFT_MAKE) begin
        shift_held_next = 1'b1;
      end else if (scan_code == scle_pkg::SC_LSHIFT_BREAK ||
                   scan_code == scle_pkg::SC_RSHIFT_BREAK) begin
        shift_held_next = 1'b0;
      end else if (scan_code[scle_pkg::RELEASE_BIT]) begin
        push = 1'b0;
      end else if (scan_code == scle_pkg::SC_BKSP) begin
        push        = 1'b1;
        push_cmd.op = scle_pkg::OP_BKSP;
      end else if (scan_code == scle_pkg::SC_ENTER) begin
        push        = 1'b1;
        push_cmd.op = scle_pkg::OP_ENTER;
      end else if (scan_code <= scle_pkg::MAP_TOP) begin
        push        = 1'b1;
        push_cmd.op = scle_pkg::OP_CHAR;
        push_cmd.ch = use_upper ? scle_pkg::MAP_UPPER[scan_code[5:0]]
                                : scle_pkg::MAP_LOWER[scan_code[5:0]];
      end else begin
        // Codes past the character tables are dropped.
        push = 1'b0;
      end
    end
  end

  // Modifier flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      caps_on    <= 1'b0;
    end else begin
      shift_held <= shift_held_next;
      caps_on    <= caps_on_next;
    end
  end

endmodule

// ===== rtl/scle_back.sv =====
`include "scancode_line_editor_core_macros.svh"

module scle_back #(
  parameter int unsigned LINE_DEPTH = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  scle_pkg::cmd_t     head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_kind,
  output logic [7:0]         char_code,
  output logic               run_last
);

  localparam int unsigned CNT_W = $clog2(LINE_DEPTH + 1);
  localparam int unsigned IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LINE_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_LINE
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   rd_idx_inc;
  logic [CNT_W-1:0]   rd_addr;
  logic [7:0]         rd_data;
  logic [7:0]         line_mem [LINE_DEPTH];
  logic               out_free;
  logic               out_load;
  logic               wr_en;
  logic               line_end;

  assign out_free   = !out_valid || out_ready;
  assign pop        = (state == S_IDLE) && !q_empty && out_free;
  assign wr_en      = pop && (head.op == scle_pkg::OP_CHAR) && (count < DEPTH_C);
  assign rd_idx_inc = CNT_W'(rd_idx + 1'b1);
  assign line_end   = (rd_idx_inc == count);

  // A new result enters the output register when the slot is free and the
  // current command or playback step has one to give.
  always_comb begin
    out_load = 1'b0;
    if (state == S_LINE) begin
      out_load = out_free;
    end else if (pop) begin
      unique case (head.op)
        scle_pkg::OP_CHAR:  out_load = (count < DEPTH_C);
        scle_pkg::OP_BKSP:  out_load = (count != '0);
        scle_pkg::OP_ENTER: out_load = 1'b1;
        default:            out_load = 1'b0;
      endcase
    end
  end

  // Read address runs one step ahead so the registered data is ready when
  // the output slot frees up.
  always_comb begin
    if (state == S_LINE) begin
      rd_addr = out_free ? rd_idx_inc : rd_idx;
    end else begin
      rd_addr = '0;
    end
  end

  // Line store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[count[IDX_W-1:0]] <= head.ch;
    end
    rd_data <= line_mem[rd_addr[IDX_W-1:0]];
  end

  // Command execution and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (head.op)
              scle_pkg::OP_CHAR: begin
                if (count < DEPTH_C) begin
                  count       <= count + 1'b1;
                  result_kind <= scle_pkg::KIND_ECHO;
                  char_code   <= head.ch;
                  run_last    <= 1'b1;
                end
              end
              scle_pkg::OP_BKSP: begin
                if (count != '0) begin
                  count       <= count - 1'b1;
                  result_kind <= scle_pkg::KIND_ERASE;
                  char_code   <= '0;
                  run_last    <= 1'b1;
                end
              end
              scle_pkg::OP_ENTER: begin
                result_kind <= scle_pkg::KIND_NEWLINE;
                char_code   <= '0;
                run_last    <= (count == '0);
                if (count != '0) begin
                  rd_idx <= '0;
                  state  <= S_LINE;
                end
              end
              default: begin
                count <= count;
              end
            endcase
          end
        end
        S_LINE: begin
          if (out_free) begin
            result_kind <= scle_pkg::KIND_LINE;
            char_code   <= rd_data;
            run_last    <= line_end;
            if (line_end) begin
              count <= '0;
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx_inc;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SCLE_ASSERT_ALWAYS(a_count_in_range, clk, rst || (count <= DEPTH_C))
  `SCLE_ASSERT(a_playback_within_line, clk, rst,
               (state == S_LINE) |-> (count != '0) && (rd_idx < count))

endmodule
